FILE: rtl/core/sslw_pkg.sv
`timescale 1ns / 1ps
// Package for the stream stall/latency watchdog.
// Holds action codes, register indexes, register reset values and the
// configuration struct. No dependencies.
package sslw_pkg;

    // Default width of a millisecond timestamp
    localparam int DEFAULT_TIME_BITS = 48;

    // Configuration port geometry
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 24;

    // Register field widths
    localparam int MS_BITS      = 24;
    localparam int LATENCY_BITS = 16;
    localparam int COUNT_BITS   = 8;
    localparam int ACTION_BITS  = 3;

    // Output tdata is the action, padded to a whole byte
    localparam int OUT_TDATA_BITS = ((ACTION_BITS + 7) / 8) * 8;

    // Watchdog answers
    typedef enum logic [ACTION_BITS-1:0] {
        ACT_NONE              = 3'd0,
        ACT_KEYFRAME          = 3'd1,
        ACT_RECONNECT_STARTUP = 3'd2,
        ACT_RECONNECT_STALL   = 3'd3,
        ACT_RECONNECT_LATENCY = 3'd4
    } action_t;

    // Item kinds carried on tuser
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_CHECK = 1'b1;

    // Register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_STARTUP_RECONNECT = 3'd0,
        REG_STARTUP_KEYFRAME  = 3'd1,
        REG_ACTIVE_RECONNECT  = 3'd2,
        REG_ACTIVE_KEYFRAME   = 3'd3,
        REG_SAMPLE_INTERVAL   = 3'd4,
        REG_LATENCY_LIMIT     = 3'd5,
        REG_HIGH_SAMPLE_LIMIT = 3'd6,
        REG_KEYFRAME_COOLDOWN = 3'd7
    } cfg_index_t;

    // Register reset values
    localparam logic [MS_BITS-1:0]      RST_STARTUP_RECONNECT = 24'd15000;
    localparam logic [MS_BITS-1:0]      RST_STARTUP_KEYFRAME  = 24'd3000;
    localparam logic [MS_BITS-1:0]      RST_ACTIVE_RECONNECT  = 24'd8000;
    localparam logic [MS_BITS-1:0]      RST_ACTIVE_KEYFRAME   = 24'd1000;
    localparam logic [MS_BITS-1:0]      RST_SAMPLE_INTERVAL   = 24'd1000;
    localparam logic [LATENCY_BITS-1:0] RST_LATENCY_LIMIT     = 16'd300;
    localparam logic [COUNT_BITS-1:0]   RST_HIGH_SAMPLE_LIMIT = 8'd5;
    localparam logic [MS_BITS-1:0]      RST_KEYFRAME_COOLDOWN = 24'd2000;

    // Current configuration as seen by the decision logic
    typedef struct packed {
        logic [MS_BITS-1:0]      startup_reconnect_ms;
        logic [MS_BITS-1:0]      startup_keyframe_ms;
        logic [MS_BITS-1:0]      active_reconnect_ms;
        logic [MS_BITS-1:0]      active_keyframe_ms;
        logic [MS_BITS-1:0]      sample_interval_ms;
        logic [LATENCY_BITS-1:0] latency_limit_ms;
        logic [COUNT_BITS-1:0]   high_sample_limit;
        logic [MS_BITS-1:0]      keyframe_cooldown_ms;
    } cfg_t;

endpackage

FILE: rtl/core/stream_stall_latency_watchdog.sv
`timescale 1ns / 1ps
// Top level of the stream stall/latency watchdog: input register, decision
// logic, output register. Depends on sslw_pkg, sslw_cfg_regs, sslw_eval.
//
//  port group   | dir | contents
//  -------------+-----+-------------------------------------------------
//  s_axis_*     | in  | one check or session start per transaction
//  m_axis_*     | out | one action per input transaction
//  cfg_*        | in  | register writes, index 0..7
//
//  One transaction per cycle sustained while m_axis_tready is high; the action
//  reaches m_axis through the input register and then the output register.
//  The decision for a transaction is made as it moves from the input register
//  to the output register, so back-to-back items see each other's state.
//  A stalled output holds its action; the input register keeps taking a
//  transaction whenever the item ahead of it can move on.
//  rst_n clears all control and session state and loads register defaults.
module stream_stall_latency_watchdog
    import sslw_pkg::*;
#(
    parameter int TIME_BITS = DEFAULT_TIME_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // Input stream
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // tdata, low to high: now_time, frame_seen, last_frame_time, latency_ok,
    // latency_value, zero pad
    input  logic [((2*TIME_BITS+LATENCY_BITS+2+7)/8)*8-1:0] s_axis_tdata,
    // tuser: mode
    input  logic                      s_axis_tuser,
    // Output stream
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // tdata, low to high: action, zero pad
    output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
    // Configuration
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int FLD_BITS = 2*TIME_BITS + LATENCY_BITS + 2;
    localparam int FRAME_POS = TIME_BITS;
    localparam int LFT_LO    = TIME_BITS + 1;
    localparam int LOK_POS   = 2*TIME_BITS + 1;
    localparam int LAT_LO    = 2*TIME_BITS + 2;

    cfg_t cfg;

    logic                in_valid_reg;
    logic                in_mode_reg;
    logic [FLD_BITS-1:0] in_data_reg;
    logic                out_valid_reg;
    action_t             out_action_reg;
    action_t             action;
    logic                out_load;
    logic                in_load;

    sslw_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    sslw_eval #(
        .TIME_BITS (TIME_BITS)
    ) u_eval (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (out_load),
        .cfg             (cfg),
        .mode            (in_mode_reg),
        .now_time        (in_data_reg[TIME_BITS-1:0]),
        .frame_seen      (in_data_reg[FRAME_POS]),
        .last_frame_time (in_data_reg[LFT_LO +: TIME_BITS]),
        .latency_ok      (in_data_reg[LOK_POS]),
        .latency_value   (in_data_reg[LAT_LO +: LATENCY_BITS]),
        .action          (action)
    );

    // Pipeline flow control
    assign out_load      = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || out_load;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (!out_valid_reg || m_axis_tready)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_mode_reg <= s_axis_tuser;
            in_data_reg <= s_axis_tdata[FLD_BITS-1:0];
        end
        if (out_load)
        begin
            out_action_reg <= action;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_BITS'(out_action_reg);

    // An accepted transaction lands in the input register
    a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> in_valid_reg)
        else $error("accepted transaction lost at input register");

    // A held input transaction is not dropped
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_load |=> in_valid_reg)
        else $error("input register dropped a waiting transaction");

    // A decision always produces an output
    a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("decision did not reach output register");

endmodule

FILE: rtl/core/sslw_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file of the watchdog: eight write-only registers.
// Depends on sslw_pkg.
module sslw_cfg_regs
    import sslw_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      we,
    input  logic [CFG_INDEX_BITS-1:0] index,
    input  logic [CFG_DATA_BITS-1:0]  data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (we)
        begin
            case (cfg_index_t'(index))
                REG_STARTUP_RECONNECT: cfg_next.startup_reconnect_ms = data;
                REG_STARTUP_KEYFRAME:  cfg_next.startup_keyframe_ms  = data;
                REG_ACTIVE_RECONNECT:  cfg_next.active_reconnect_ms  = data;
                REG_ACTIVE_KEYFRAME:   cfg_next.active_keyframe_ms   = data;
                REG_SAMPLE_INTERVAL:   cfg_next.sample_interval_ms   = data;
                REG_LATENCY_LIMIT:     cfg_next.latency_limit_ms     = data[LATENCY_BITS-1:0];
                REG_HIGH_SAMPLE_LIMIT: cfg_next.high_sample_limit    = data[COUNT_BITS-1:0];
                REG_KEYFRAME_COOLDOWN: cfg_next.keyframe_cooldown_ms = data;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.startup_reconnect_ms <= RST_STARTUP_RECONNECT;
            cfg_reg.startup_keyframe_ms  <= RST_STARTUP_KEYFRAME;
            cfg_reg.active_reconnect_ms  <= RST_ACTIVE_RECONNECT;
            cfg_reg.active_keyframe_ms   <= RST_ACTIVE_KEYFRAME;
            cfg_reg.sample_interval_ms   <= RST_SAMPLE_INTERVAL;
            cfg_reg.latency_limit_ms     <= RST_LATENCY_LIMIT;
            cfg_reg.high_sample_limit    <= RST_HIGH_SAMPLE_LIMIT;
            cfg_reg.keyframe_cooldown_ms <= RST_KEYFRAME_COOLDOWN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/core/sslw_eval.sv
`timescale 1ns / 1ps
// Decision logic and session state of the watchdog: one transaction per
// cycle, state updated when fire is high. Depends on sslw_pkg.
module sslw_eval
    import sslw_pkg::*;
#(
    parameter int TIME_BITS = DEFAULT_TIME_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    fire,
    input  cfg_t                    cfg,
    input  logic                    mode,
    input  logic [TIME_BITS-1:0]    now_time,
    input  logic                    frame_seen,
    input  logic [TIME_BITS-1:0]    last_frame_time,
    input  logic                    latency_ok,
    input  logic [LATENCY_BITS-1:0] latency_value,
    output action_t                 action
);

    logic [TIME_BITS-1:0]  session_start_reg, session_start_next;
    logic [TIME_BITS-1:0]  last_sample_reg,   last_sample_next;
    logic                  kf_pending_reg,    kf_pending_next;
    logic [TIME_BITS-1:0]  last_kf_reg,       last_kf_next;
    logic [COUNT_BITS-1:0] count_reg,         count_next;

    logic [TIME_BITS-1:0]  ref_time;
    logic [TIME_BITS-1:0]  age;
    logic [TIME_BITS-1:0]  kf_elapsed;
    logic [TIME_BITS-1:0]  sample_elapsed;
    logic [MS_BITS-1:0]    kf_thresh;
    logic                  kf_age_hit;
    logic                  kf_allowed;
    logic                  sample_due;
    logic                  high_sample;
    logic [COUNT_BITS-1:0] count_step;

    // Wrapping ages; the progress reference depends on whether a frame arrived
    assign ref_time       = frame_seen ? last_frame_time : session_start_reg;
    assign age            = now_time - ref_time;
    assign kf_elapsed     = now_time - last_kf_reg;
    assign sample_elapsed = now_time - last_sample_reg;

    assign kf_thresh  = frame_seen ? cfg.active_keyframe_ms : cfg.startup_keyframe_ms;
    assign kf_age_hit = age >= TIME_BITS'(kf_thresh);
    assign kf_allowed = !kf_pending_reg
                        || (kf_elapsed >= TIME_BITS'(cfg.keyframe_cooldown_ms));
    assign sample_due = sample_elapsed >= TIME_BITS'(cfg.sample_interval_ms);

    // High latency sample: increment with saturation, anything else clears
    assign high_sample = latency_ok && (latency_value > cfg.latency_limit_ms);
    assign count_step  = !high_sample ? '0
                       : (&count_reg) ? count_reg
                       : count_reg + COUNT_BITS'(1);

    // Action and state update
    always_comb
    begin
        action             = ACT_NONE;
        session_start_next = session_start_reg;
        last_sample_next   = last_sample_reg;
        kf_pending_next    = kf_pending_reg;
        last_kf_next       = last_kf_reg;
        count_next         = count_reg;

        if (mode == MODE_START)
        begin
            session_start_next = now_time;
            last_sample_next   = now_time;
            kf_pending_next    = 1'b0;
            last_kf_next       = '0;
            count_next         = '0;
        end
        else if (!frame_seen)
        begin
            count_next = '0;
            if (age >= TIME_BITS'(cfg.startup_reconnect_ms))
            begin
                action = ACT_RECONNECT_STARTUP;
            end
            else if (kf_age_hit && kf_allowed)
            begin
                action          = ACT_KEYFRAME;
                kf_pending_next = 1'b1;
                last_kf_next    = now_time;
            end
        end
        else if (age >= TIME_BITS'(cfg.active_reconnect_ms))
        begin
            action = ACT_RECONNECT_STALL;
        end
        else if (sample_due && (count_step >= cfg.high_sample_limit))
        begin
            last_sample_next = now_time;
            count_next       = count_step;
            action           = ACT_RECONNECT_LATENCY;
        end
        else
        begin
            if (sample_due)
            begin
                last_sample_next = now_time;
                count_next       = count_step;
            end
            if (kf_age_hit && kf_allowed)
            begin
                action          = ACT_KEYFRAME;
                kf_pending_next = 1'b1;
                last_kf_next    = now_time;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_start_reg <= '0;
            last_sample_reg   <= '0;
            kf_pending_reg    <= 1'b0;
            last_kf_reg       <= '0;
            count_reg         <= '0;
        end
        else if (fire)
        begin
            session_start_reg <= session_start_next;
            last_sample_reg   <= last_sample_next;
            kf_pending_reg    <= kf_pending_next;
            last_kf_reg       <= last_kf_next;
            count_reg         <= count_next;
        end
    end

    // Session start clears the key frame and sample history
    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (mode == MODE_START) |=> (count_reg == '0) && !kf_pending_reg)
        else $error("session start did not clear state");

    // A granted key frame arms the cooldown at the current time
    a_kf_arms: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (action == ACT_KEYFRAME) |=>
            kf_pending_reg && (last_kf_reg == $past(now_time)))
        else $error("key frame request did not arm cooldown");

    // Without any frame the high sample count is held at zero
    a_noframe_count: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (mode == MODE_CHECK) && !frame_seen |=> count_reg == '0)
        else $error("high sample count not cleared without frames");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for stream_stall_latency_watchdog: drives checks and session
// starts with random idling, predicts every action and compares on m_axis.
// Depends on sslw_pkg and the RTL under rtl/core.
module tb;
    import sslw_pkg::*;

    localparam int TIME_BITS       = DEFAULT_TIME_BITS;
    localparam int IN_TDATA_BITS   = ((2*TIME_BITS+LATENCY_BITS+2+7)/8)*8;
    localparam int WATCHDOG_CYCLES = 2000;

    typedef logic [TIME_BITS-1:0] ms_t;

    // One input transaction before packing
    typedef struct {
        logic                    mode;
        ms_t                     now_ms;
        logic                    frame_seen;
        ms_t                     frame_ms;
        logic                    lat_ok;
        logic [LATENCY_BITS-1:0] lat_ms;
    } health_item_t;

    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    // tdata, low to high: now_time, frame_seen, last_frame_time, latency_ok,
    // latency_value, zero pad
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata  = '0;
    // tuser: mode
    logic                      s_axis_tuser  = MODE_START;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    // tdata, low to high: action, zero pad
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
    logic                      cfg_we        = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index     = REG_STARTUP_RECONNECT;
    logic [CFG_DATA_BITS-1:0]  cfg_data      = '0;

    // Stimulus and scoreboard
    health_item_t health_q[$];
    action_t      expected_actions[$];
    int           queued       = 0;
    int           mismatches   = 0;
    int           quiet_cycles = 0;
    bit           steady       = 1'b0;
    bit           in_fire      = 1'b0;
    bit           out_fire     = 1'b0;
    int           gap_left     = 0;
    int           stall_left   = 0;

    // Register mirror
    logic [MS_BITS-1:0]      thr_startup_rc = RST_STARTUP_RECONNECT;
    logic [MS_BITS-1:0]      thr_startup_kf = RST_STARTUP_KEYFRAME;
    logic [MS_BITS-1:0]      thr_active_rc  = RST_ACTIVE_RECONNECT;
    logic [MS_BITS-1:0]      thr_active_kf  = RST_ACTIVE_KEYFRAME;
    logic [MS_BITS-1:0]      sample_gap_ms  = RST_SAMPLE_INTERVAL;
    logic [LATENCY_BITS-1:0] lat_limit_ms   = RST_LATENCY_LIMIT;
    logic [COUNT_BITS-1:0]   high_limit     = RST_HIGH_SAMPLE_LIMIT;
    logic [MS_BITS-1:0]      kf_cooldown_ms = RST_KEYFRAME_COOLDOWN;

    // Session state mirror
    ms_t                   sess_start_ms = '0;
    ms_t                   sample_ms     = '0;
    logic                  kf_pending    = 1'b0;
    ms_t                   kf_ms         = '0;
    logic [COUNT_BITS-1:0] high_count    = '0;

    stream_stall_latency_watchdog #(
        .TIME_BITS(TIME_BITS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Key frame rate limit; grants update the cooldown state
    function automatic bit keyframe_grant(ms_t now_ms);
        ms_t since;
        since = now_ms - kf_ms;
        if (kf_pending && since < kf_cooldown_ms)
            return 1'b0;
        kf_pending = 1'b1;
        kf_ms      = now_ms;
        return 1'b1;
    endfunction

    // Action for one transaction, advancing the session state
    function automatic action_t watchdog_action(health_item_t it);
        ms_t     age;
        ms_t     since_sample;
        action_t act;
        act = ACT_NONE;
        if (it.mode == MODE_START)
        begin
            sess_start_ms = it.now_ms;
            sample_ms     = it.now_ms;
            kf_pending    = 1'b0;
            kf_ms         = '0;
            high_count    = '0;
            return ACT_NONE;
        end
        if (!it.frame_seen)
        begin
            age        = it.now_ms - sess_start_ms;
            high_count = '0;
            if (age >= thr_startup_rc)
                act = ACT_RECONNECT_STARTUP;
            else if (age >= thr_startup_kf && keyframe_grant(it.now_ms))
                act = ACT_KEYFRAME;
            return act;
        end
        age = it.now_ms - it.frame_ms;
        if (age >= thr_active_rc)
            return ACT_RECONNECT_STALL;
        since_sample = it.now_ms - sample_ms;
        if (since_sample >= sample_gap_ms)
        begin
            sample_ms = it.now_ms;
            if (it.lat_ok && it.lat_ms > lat_limit_ms)
            begin
                if (high_count != '1)
                    high_count++;
            end
            else
                high_count = '0;
            if (high_count >= high_limit)
                return ACT_RECONNECT_LATENCY;
        end
        if (age >= thr_active_kf && keyframe_grant(it.now_ms))
            act = ACT_KEYFRAME;
        return act;
    endfunction

    // Sender: new transaction at the falling edge, random idle bursts
    always @(negedge clk)
    begin
        health_item_t it;
        if (rst_n && (!s_axis_tvalid || in_fire))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 7) == 0)
            begin
                gap_left = $urandom_range(0, 8);
                s_axis_tvalid <= 1'b0;
            end
            else if (health_q.size() > 0)
            begin
                it = health_q.pop_front();
                s_axis_tuser  <= it.mode;
                s_axis_tdata  <= IN_TDATA_BITS'({it.lat_ms, it.lat_ok, it.frame_ms,
                                                 it.frame_seen, it.now_ms});
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver: random backpressure bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!steady && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 8);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Monitor: check results, predict accepted transactions, watchdog
    always @(posedge clk)
    begin : monitor
        health_item_t it;
        action_t      want;
        in_fire  = rst_n && s_axis_tvalid && s_axis_tready;
        out_fire = rst_n && m_axis_tvalid && m_axis_tready;
        if (out_fire)
        begin
            if (expected_actions.size() == 0)
            begin
                $error("action: expected no transaction, actual %0d",
                       m_axis_tdata[ACTION_BITS-1:0]);
                mismatches++;
            end
            else
            begin
                want = expected_actions.pop_front();
                if (m_axis_tdata[ACTION_BITS-1:0] !== want)
                begin
                    $error("action: expected %0d, actual %0d", want,
                           m_axis_tdata[ACTION_BITS-1:0]);
                    mismatches++;
                end
            end
        end
        if (in_fire)
        begin
            it.mode       = s_axis_tuser;
            it.now_ms     = s_axis_tdata[TIME_BITS-1:0];
            it.frame_seen = s_axis_tdata[TIME_BITS];
            it.frame_ms   = s_axis_tdata[2*TIME_BITS:TIME_BITS+1];
            it.lat_ok     = s_axis_tdata[2*TIME_BITS+1];
            it.lat_ms     = s_axis_tdata[2*TIME_BITS+LATENCY_BITS+1:2*TIME_BITS+2];
            expected_actions.push_back(watchdog_action(it));
        end
        if (in_fire || out_fire)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("stream_stall_latency_watchdog: mismatch");
            $finish;
        end
    end

    task automatic add_item(logic mode, ms_t now_ms, logic frame_seen, ms_t frame_ms,
                            logic lat_ok, logic [LATENCY_BITS-1:0] lat_ms);
        health_item_t it;
        it = '{mode, now_ms, frame_seen, frame_ms, lat_ok, lat_ms};
        health_q.push_back(it);
        queued++;
    endtask

    function automatic ms_t rand_ms();
        return ms_t'({$urandom, $urandom});
    endfunction

    // Time advance between checks, biased toward the sampling interval
    function automatic ms_t next_step();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, 500);
            4, 5:       return sample_gap_ms + $urandom_range(0, 50);
            6, 7:       return $urandom_range(0, 3000);
            8:          return $urandom_range(0, 20000);
            default:    return $urandom;
        endcase
    endfunction

    // Well-formed session: start, checks without frames, then with frames
    task automatic push_session(int checks, bit hot);
        ms_t                     t;
        ms_t                     lf;
        int                      first_frame;
        bit                      warm;
        bit                      ok;
        logic [LATENCY_BITS-1:0] lat;
        t = rand_ms();
        if ($urandom_range(0, 3) == 0)
            t = '1 - $urandom_range(0, 20000);
        warm        = hot || $urandom_range(0, 1);
        first_frame = hot ? 0 : $urandom_range(0, checks);
        add_item(MODE_START, t, 1'b0, rand_ms(), $urandom_range(0, 1), $urandom);
        lf = t;
        for (int k = 0; k < checks; k++)
        begin
            t = t + next_step();
            if (k >= first_frame)
            begin
                case ($urandom_range(0, 19))
                    0:                        lf = t + $urandom_range(1, 100);
                    1, 2, 3, 4, 5, 6, 7, 8, 9,
                    10, 11:                   lf = t - $urandom_range(0, 300);
                    default:                  ;
                endcase
            end
            ok = hot || $urandom_range(0, 9) != 0;
            if (warm && (hot || $urandom_range(0, 6) != 0))
                lat = (lat_limit_ms > 16'hFFFF - 16'd400) ? '1
                                                         : lat_limit_ms + $urandom_range(1, 400);
            else
                lat = $urandom_range(0, lat_limit_ms);
            if (!hot && $urandom_range(0, 9) == 0)
                lat = $urandom;
            add_item(MODE_CHECK, t, k >= first_frame, (k >= first_frame) ? lf : rand_ms(),
                     ok, lat);
        end
    endtask

    // Sessions mixed with unstructured transactions
    task automatic random_traffic(int count);
        int base;
        base = queued;
        while (queued - base < count)
        begin
            if ($urandom_range(0, 9) == 0)
                add_item(($urandom_range(0, 4) == 0) ? MODE_START : MODE_CHECK, rand_ms(),
                         $urandom_range(0, 1), rand_ms(), $urandom_range(0, 1), $urandom);
            else
                push_session($urandom_range(3, 25), 1'b0);
        end
    endtask

    // Wait until every transaction has gone through and the pipe is empty
    task automatic drain();
        while (health_q.size() != 0 || s_axis_tvalid || expected_actions.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_STARTUP_RECONNECT: thr_startup_rc = val[MS_BITS-1:0];
            REG_STARTUP_KEYFRAME:  thr_startup_kf = val[MS_BITS-1:0];
            REG_ACTIVE_RECONNECT:  thr_active_rc  = val[MS_BITS-1:0];
            REG_ACTIVE_KEYFRAME:   thr_active_kf  = val[MS_BITS-1:0];
            REG_SAMPLE_INTERVAL:   sample_gap_ms  = val[MS_BITS-1:0];
            REG_LATENCY_LIMIT:     lat_limit_ms   = val[LATENCY_BITS-1:0];
            REG_HIGH_SAMPLE_LIMIT: high_limit     = val[COUNT_BITS-1:0];
            REG_KEYFRAME_COOLDOWN: kf_cooldown_ms = val[MS_BITS-1:0];
            default:               ;
        endcase
    endtask

    // Write all eight registers, then release the write enable
    task automatic load_regs(logic [CFG_DATA_BITS-1:0] startup_rc, startup_kf,
                             active_rc, active_kf, sample_gap, lat_limit,
                             hi_limit, cooldown);
        set_reg(REG_STARTUP_RECONNECT, startup_rc);
        set_reg(REG_STARTUP_KEYFRAME, startup_kf);
        set_reg(REG_ACTIVE_RECONNECT, active_rc);
        set_reg(REG_ACTIVE_KEYFRAME, active_kf);
        set_reg(REG_SAMPLE_INTERVAL, sample_gap);
        set_reg(REG_LATENCY_LIMIT, lat_limit);
        set_reg(REG_HIGH_SAMPLE_LIMIT, hi_limit);
        set_reg(REG_KEYFRAME_COOLDOWN, cooldown);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_BITS-1:0] pick_ms();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 50);
            1:       return $urandom_range(200, 5000);
            2:       return $urandom_range(1000, 20000);
            default: return CFG_DATA_BITS'($urandom);
        endcase
    endfunction

    // Stimulus sequence
    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: key frame cooldown, each reconnect, latency run, wrap
        add_item(MODE_START, 48'd1000, 1'b0, '0, 1'b0, '0);
        add_item(MODE_CHECK, 48'd1000, 1'b0, '0, 1'b0, '0);
        add_item(MODE_CHECK, 48'd4000, 1'b0, '0, 1'b1, 16'd500);
        add_item(MODE_CHECK, 48'd5000, 1'b0, '0, 1'b1, 16'd500);
        add_item(MODE_CHECK, 48'd6000, 1'b0, '0, 1'b1, 16'd500);
        add_item(MODE_CHECK, 48'd16000, 1'b0, '0, 1'b1, 16'd500);
        add_item(MODE_CHECK, 48'd16000, 1'b1, 48'd8000, 1'b1, 16'd10);
        // frame timestamp ahead of now
        add_item(MODE_CHECK, 48'd16000, 1'b1, 48'd16005, 1'b1, 16'd10);
        for (int k = 0; k < 5; k++)
            add_item(MODE_CHECK, 48'd17000 + 1000 * k, 1'b1, 48'd16990 + 1000 * k,
                     1'b1, 16'd301);
        add_item(MODE_CHECK, 48'd22000, 1'b1, 48'd21990, 1'b1, 16'd300);
        add_item(MODE_CHECK, 48'd23000, 1'b1, 48'd22990, 1'b0, 16'hFFFF);
        add_item(MODE_CHECK, 48'd23500, 1'b1, 48'd22500, 1'b1, 16'd0);
        add_item(MODE_START, 48'hFFFF_FFFF_FFF0, 1'b0, '0, 1'b0, '0);
        add_item(MODE_CHECK, 48'h10, 1'b0, '1, 1'b1, '1);
        add_item(MODE_CHECK, '1, 1'b1, '1, 1'b1, '1);
        add_item(MODE_START, '0, 1'b1, '1, 1'b1, '1);
        drain();

        // All thresholds at zero
        load_regs('0, '0, '0, '0, '0, '0, '0, '0);
        random_traffic(50);
        drain();

        // All thresholds at their maximum
        load_regs('1, '1, '1, '1, '1, 16'hFFFF, 8'hFF, '1);
        random_traffic(60);
        drain();

        // Every sample counted and high: the counter runs into saturation
        load_regs('1, '1, '1, '1, '0, '0, 8'd255, 24'd2000);
        push_session(280, 1'b1);
        drain();

        // Zero high sample limit
        load_regs(24'd15000, 24'd3000, 24'd8000, 24'd1000, 24'd1000, 24'd300, '0,
                  24'd2000);
        random_traffic(80);
        drain();

        // Random settings
        repeat (4)
        begin
            load_regs(pick_ms(), pick_ms(), pick_ms(), pick_ms(), pick_ms(),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                  : $urandom_range(0, 1000),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 8),
                      pick_ms());
            random_traffic(90);
            drain();
        end

        // Back to defaults, full throughput on both sides
        load_regs(RST_STARTUP_RECONNECT, RST_STARTUP_KEYFRAME, RST_ACTIVE_RECONNECT,
                  RST_ACTIVE_KEYFRAME, RST_SAMPLE_INTERVAL, RST_LATENCY_LIMIT,
                  RST_HIGH_SAMPLE_LIMIT, RST_KEYFRAME_COOLDOWN);
        steady = 1'b1;
        random_traffic(100);
        drain();
        repeat (8) @(posedge clk);

        if (mismatches == 0)
            $display("stream_stall_latency_watchdog: match");
        else
            $display("stream_stall_latency_watchdog: mismatch");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/sslw_pkg.sv
rtl/core/sslw_cfg_regs.sv
rtl/core/sslw_eval.sv
rtl/core/stream_stall_latency_watchdog.sv
dv/tb.sv
